/* rtl/core/wbc_pkg.sv */
package wbc_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_PIXELS = 16777216;

  localparam int unsigned THRESH_W   = 10;
  localparam int unsigned IMG_W      = 13;
  localparam int unsigned COL_W      = 12;
  localparam int unsigned SUM_W      = 36;
  localparam int unsigned COUNT_W    = 25;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd170;
  localparam logic [IMG_W-1:0]    WIDTH_RESET  = 13'd640;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 1'd1;

  localparam logic [1:0] STEER_STOP     = 2'd0;
  localparam logic [1:0] STEER_LEFT     = 2'd1;
  localparam logic [1:0] STEER_STRAIGHT = 2'd2;
  localparam logic [1:0] STEER_RIGHT    = 2'd3;

  localparam logic [COL_W-1:0] CENTROID_MAX = 12'd4095;

  // floor(x / 3) == (x * RECIP3) >> 16 for x below 32768
  localparam logic [14:0] RECIP3 = 15'd21846;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;

  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned DIV_CNT_W = 6;

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
  } frame_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_HOLD
  } back_state_t;

endpackage

/* rtl/core/wbc_front.sv */
module wbc_front #(
  parameter int unsigned MAX_PIXELS = wbc_pkg::DEF_MAX_PIXELS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [wbc_pkg::THRESH_W-1:0]  threshold,
  input  logic [wbc_pkg::IMG_W-1:0]     width,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    red,
  input  logic [7:0]                    green,
  input  logic [7:0]                    blue,
  input  logic                          frame_end,
  output logic                          push_valid,
  input  logic                          push_ready,
  output wbc_pkg::frame_t               push_data
);
  import wbc_pkg::*;

  localparam int unsigned COUNT_FIELD_MAX = (1 << COUNT_W) - 1;
  localparam logic [COUNT_W-1:0] COUNT_CAP =
    (MAX_PIXELS < COUNT_FIELD_MAX) ? COUNT_W'(MAX_PIXELS) : COUNT_W'(COUNT_FIELD_MAX);

  logic [COL_W-1:0]   column;
  logic [SUM_W-1:0]   sum;
  logic [COUNT_W-1:0] count;

  logic [COL_W-1:0]   column_next;
  logic [SUM_W-1:0]   sum_next;
  logic [COUNT_W-1:0] count_next;

  logic [THRESH_W-1:0] luma;
  logic                bright;
  logic [IMG_W-1:0]    col_cur;
  logic [IMG_W-1:0]    col_inc;
  logic [SUM_W:0]      sum_add;
  logic                accept;

  assign in_ready = !frame_end || push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    luma    = THRESH_W'(red) + THRESH_W'(green) + THRESH_W'(blue);
    bright  = luma >= threshold;
    col_cur = {1'b0, column};
    if (col_cur >= width) begin
      col_cur = '0;
    end
    col_inc = col_cur + 1'b1;
    if (col_inc >= width) begin
      col_inc = '0;
    end
    sum_add    = {1'b0, sum} + (SUM_W + 1)'(col_cur);
    sum_next   = sum;
    count_next = count;
    if (bright) begin
      sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      if (count < COUNT_CAP) begin
        count_next = count + 1'b1;
      end
    end
    column_next = col_inc[COL_W-1:0];
  end

  assign push_valid      = in_valid && frame_end;
  assign push_data.sum   = sum_next;
  assign push_data.count = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      sum    <= '0;
      count  <= '0;
    end else if (accept) begin
      if (frame_end) begin
        column <= '0;
        sum    <= '0;
        count  <= '0;
      end else begin
        column <= column_next;
        sum    <= sum_next;
        count  <= count_next;
      end
    end
  end

endmodule

/* rtl/core/wbc_queue.sv */
module wbc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  wbc_pkg::frame_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output wbc_pkg::frame_t pop_data
);
  import wbc_pkg::*;

  frame_t               entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_AW:0]    fill;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = fill != (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* rtl/core/wbc_back.sv */
module wbc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [wbc_pkg::IMG_W-1:0]  width,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  wbc_pkg::frame_t            pop_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 steer,
  output logic [wbc_pkg::COL_W-1:0]  centroid_column
);
  import wbc_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [COUNT_W:0]     rem;
  logic [SUM_W-1:0]     quo;
  logic [COUNT_W-1:0]   divisor;
  logic [DIV_CNT_W-1:0] step;
  logic                 empty;
  logic [COL_W-1:0]     band_low;
  logic [IMG_W-1:0]     band_high;

  logic                 load;
  logic                 finish;
  logic [COUNT_W:0]     trial;
  logic                 fits;
  logic [27:0]          low_prod;
  logic [28:0]          high_prod;
  logic [COL_W-1:0]     cent_c;
  logic [1:0]           steer_c;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (pop_valid) begin
          state_next = (pop_data.count == '0) ? BK_HOLD : BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        if (step == '0) begin
          state_next = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (!out_valid || out_ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    load   = 1'b0;
    finish = 1'b0;
    case (state)
      BK_IDLE: load   = pop_valid;
      BK_HOLD: finish = !out_valid || out_ready;
      default: begin
        load   = 1'b0;
        finish = 1'b0;
      end
    endcase
  end

  assign pop_ready = load;

  always_comb begin
    trial     = {rem[COUNT_W-1:0], quo[SUM_W-1]};
    fits      = trial >= {1'b0, divisor};
    low_prod  = {2'b0, width} * {13'b0, RECIP3};
    high_prod = {2'b0, width, 1'b0} * {14'b0, RECIP3};
    cent_c    = (|quo[SUM_W-1:COL_W]) ? CENTROID_MAX : quo[COL_W-1:0];
    if (empty) begin
      steer_c = STEER_STOP;
      cent_c  = '0;
    end else if (cent_c < band_low) begin
      steer_c = STEER_LEFT;
    end else if ({1'b0, cent_c} > band_high) begin
      steer_c = STEER_RIGHT;
    end else begin
      steer_c = STEER_STRAIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem       <= '0;
      quo       <= pop_data.sum;
      divisor   <= pop_data.count;
      step      <= DIV_CNT_W'(DIV_STEPS - 1);
      empty     <= pop_data.count == '0;
      band_low  <= low_prod[27:16];
      band_high <= high_prod[28:16];
    end else if (state == BK_DIVIDE) begin
      rem  <= fits ? trial - {1'b0, divisor} : trial;
      quo  <= {quo[SUM_W-2:0], fits};
      step <= step - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      steer           <= steer_c;
      centroid_column <= cent_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && steer == STEER_STOP |-> centroid_column == '0)
    else $error("stop result with nonzero centroid");

  a_left_band: assert property (@(posedge clk) disable iff (rst)
    out_valid && steer == STEER_LEFT |-> centroid_column < band_low)
    else $error("left result outside the left band");

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    state == BK_IDLE && pop_valid |=> state == BK_DIVIDE || state == BK_HOLD)
    else $error("queued frame not started");

  a_hold_from_last_step: assert property (@(posedge clk) disable iff (rst)
    state == BK_DIVIDE && step != '0 |=> state == BK_DIVIDE)
    else $error("division left early");
`endif

endmodule

/* rtl/core/white_blob_centroid_steer_core.sv */
// result: a frame's sums enter the queue when its last pixel is accepted, then
//   divide unless no pixel was bright; a stalled output holds the result
// throughput: one pixel per cycle while the queue has room at frame end;
//   later frames stream in during division, two finished frames queued ahead
// reset: synchronous; clears sums, column and queue; threshold 170, width 640
module white_blob_centroid_steer_core #(
  parameter int unsigned MAX_WIDTH  = wbc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_PIXELS = wbc_pkg::DEF_MAX_PIXELS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [wbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      red,
  input  logic [7:0]                      green,
  input  logic [7:0]                      blue,
  input  logic                            frame_end,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      steer,
  output logic [wbc_pkg::COL_W-1:0]       centroid_column
);
  import wbc_pkg::*;

  logic [THRESH_W-1:0] bright_threshold;
  logic [IMG_W-1:0]    image_width;
  logic [IMG_W-1:0]    width_eff;

  logic   push_valid;
  logic   push_ready;
  frame_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  frame_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      bright_threshold <= THRESH_RESET;
      image_width      <= WIDTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_THRESHOLD: bright_threshold <= cfg_data[THRESH_W-1:0];
        CFG_WIDTH:     image_width      <= cfg_data[IMG_W-1:0];
        default:       bright_threshold <= bright_threshold;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      width_eff = IMG_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      width_eff = IMG_W'(MAX_WIDTH);
    end else begin
      width_eff = image_width;
    end
  end

  wbc_front #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .threshold  (bright_threshold),
    .width      (width_eff),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .frame_end  (frame_end),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  wbc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  wbc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .width           (width_eff),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_data        (pop_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .steer           (steer),
    .centroid_column (centroid_column)
  );

endmodule
